### src/assert_macros.svh
// assertion helpers used by the checker in fct_chk.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every edge outside of reset
`define FCT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every edge, reset included
`define FCT_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/fct_pkg.sv
package fct_pkg;

   localparam int COORD_W   = 16;
   localparam int AXES      = 3;
   localparam int PLANE_W   = 64;
   localparam int FRAC_W    = 14;
   localparam int RADIUS_W  = 15;
   localparam int FUNC_W    = 2;
   localparam int VERDICT_W = 2;
   localparam int PROD_W    = 2 * COORD_W;
   // three products of up to 2^30 plus offset and radius terms, signed
   localparam int DIST_W    = PROD_W + 3;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_POINT    = 2'd0,
      FUNC_SPHERE   = 2'd1,
      FUNC_BOX      = 2'd2,
      FUNC_RESERVED = 2'd3
   } func_type;

   typedef enum logic [VERDICT_W-1:0] {
      VERDICT_OUTSIDE = 2'd0,
      VERDICT_INSIDE  = 2'd1,
      VERDICT_PARTIAL = 2'd2
   } verdict_type;

endpackage

### src/frustum_cull_test_unit.sv
// Six-plane frustum test for points, spheres and axis-aligned boxes.
// Input channel req_*: one object per beat (req_func selects point, sphere or
// box; req_a* is the point, center or box minimum, req_b* the box maximum).
// Result channel rsp_*: one verdict beat per input beat, in order
// (outside, fully inside, or partially inside for boxes).
// The user must write planes via csr_we/csr_index/csr_wdata only while idle;
// the block does not enforce it; indexes beyond the last plane are ignored.
// Pipeline: four register stages (input, corner select and multiply,
// distance sum and sign, verdict); the verdict register drives rsp_valid
// and rsp_verdict.
// Throughput: one object per clock unless rsp_ready stalls, set by the 36
// parallel 16x16 multipliers (far and near corner, six planes) in stage 2.
// Reset clears all valid bits and all plane registers; with zero planes
// every point, sphere and box tests fully inside.
// When rsp_ready is low the stages ahead of the output keep filling until
// every stage holds a beat, then req_ready drops; nothing is lost or repeated.
module frustum_cull_test_unit
   import fct_pkg::*;
#(
   parameter int  NUM_PLANES = 6,
   localparam int IDX_W      = $clog2(NUM_PLANES)
) (
   input  logic                       clock,
   input  logic                       reset,

   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [FUNC_W-1:0]          req_func,
   input  logic signed [COORD_W-1:0]  req_ax,
   input  logic signed [COORD_W-1:0]  req_ay,
   input  logic signed [COORD_W-1:0]  req_az,
   input  logic signed [COORD_W-1:0]  req_bx,
   input  logic signed [COORD_W-1:0]  req_by,
   input  logic signed [COORD_W-1:0]  req_bz,
   input  logic [RADIUS_W-1:0]        req_radius,

   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [VERDICT_W-1:0]       rsp_verdict,

   input  logic                       csr_we,
   input  logic [IDX_W-1:0]           csr_index,
   input  logic [PLANE_W-1:0]         csr_wdata
);

   // plane registers
   logic [PLANE_W-1:0]        plane_ff [NUM_PLANES];
   logic signed [COORD_W-1:0] norm     [NUM_PLANES][AXES];
   logic [COORD_W-1:0]        offs     [NUM_PLANES];

   // stage 1: registered input beat
   logic                      s1_valid_ff, s1_valid_in;
   func_type                  s1_func_ff;
   logic signed [COORD_W-1:0] s1_lo_ff [AXES];
   logic signed [COORD_W-1:0] s1_hi_ff [AXES];
   logic [RADIUS_W-1:0]       s1_radius_ff;
   logic                      s1_ready;

   // stage 2: products for far and near corners
   logic                      s2_valid_ff, s2_valid_in;
   func_type                  s2_func_ff;
   logic [RADIUS_W-1:0]       s2_radius_ff;
   logic signed [PROD_W-1:0]  s2_far_ff  [NUM_PLANES][AXES];
   logic signed [PROD_W-1:0]  s2_near_ff [NUM_PLANES][AXES];
   logic signed [PROD_W-1:0]  s2_far_in  [NUM_PLANES][AXES];
   logic signed [PROD_W-1:0]  s2_near_in [NUM_PLANES][AXES];
   logic                      s2_ready;

   // stage 3: per-plane sign results
   logic                      s3_valid_ff, s3_valid_in;
   func_type                  s3_func_ff;
   logic [NUM_PLANES-1:0]     s3_out_ff, s3_out_in;
   logic [NUM_PLANES-1:0]     s3_part_ff, s3_part_in;
   logic                      s3_ready;

   // stage 4: output register
   logic                      rsp_valid_ff, rsp_valid_in;
   verdict_type               verdict_ff, verdict_in;
   logic                      s4_ready;

   // ---------------------------------------------------------------
   // configuration
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < NUM_PLANES; p++) begin
            plane_ff[p] <= '0;
         end
      end else if (csr_we && (csr_index < IDX_W'(NUM_PLANES))) begin
         plane_ff[csr_index] <= csr_wdata;
      end
   end

   always_comb begin
      for (int p = 0; p < NUM_PLANES; p++) begin
         for (int a = 0; a < AXES; a++) begin
            norm[p][a] = plane_ff[p][COORD_W*a +: COORD_W];
         end
         offs[p] = plane_ff[p][COORD_W*AXES +: COORD_W];
      end
   end

   // ---------------------------------------------------------------
   // stall chain: a stage takes a beat when empty or when it moves on
   // ---------------------------------------------------------------
   assign s4_ready  = !rsp_valid_ff || rsp_ready;
   assign s3_ready  = !s3_valid_ff || s4_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_ready = s1_ready;

   assign s1_valid_in  = s1_ready ? req_valid   : s1_valid_ff;
   assign s2_valid_in  = s2_ready ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in  = s3_ready ? s2_valid_ff : s3_valid_ff;
   assign rsp_valid_in = s4_ready ? s3_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------------------------------------------------------
   // stage 1
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_func_ff   <= func_type'(req_func);
         s1_lo_ff[0]  <= req_ax;
         s1_lo_ff[1]  <= req_ay;
         s1_lo_ff[2]  <= req_az;
         s1_hi_ff[0]  <= req_bx;
         s1_hi_ff[1]  <= req_by;
         s1_hi_ff[2]  <= req_bz;
         s1_radius_ff <= req_radius;
      end
   end

   // ---------------------------------------------------------------
   // stage 2: corner select and multiply
   // ---------------------------------------------------------------
   always_comb begin
      logic                      is_box;
      logic signed [COORD_W-1:0] far_c;
      logic signed [COORD_W-1:0] near_c;
      is_box = (s1_func_ff == FUNC_BOX);
      for (int p = 0; p < NUM_PLANES; p++) begin
         for (int a = 0; a < AXES; a++) begin
            // far corner takes the max where the normal is non-negative;
            // point and sphere use the a coordinates for the far corner
            far_c  = (is_box && !norm[p][a][COORD_W-1]) ? s1_hi_ff[a] : s1_lo_ff[a];
            near_c = norm[p][a][COORD_W-1] ? s1_hi_ff[a] : s1_lo_ff[a];
            s2_far_in[p][a]  = norm[p][a] * far_c;
            s2_near_in[p][a] = norm[p][a] * near_c;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s2_func_ff   <= s1_func_ff;
         s2_radius_ff <= s1_radius_ff;
         s2_far_ff    <= s2_far_in;
         s2_near_ff   <= s2_near_in;
      end
   end

   // ---------------------------------------------------------------
   // stage 3: distance sums, sign tests
   // ---------------------------------------------------------------
   always_comb begin
      logic [DIST_W-1:0] off_term;
      logic [DIST_W-1:0] rad_term;
      logic [DIST_W-1:0] far_sum;
      logic [DIST_W-1:0] near_sum;
      rad_term = '0;
      if (s2_func_ff == FUNC_SPHERE) begin
         rad_term = {{(DIST_W-RADIUS_W-FRAC_W){1'b0}}, s2_radius_ff, {FRAC_W{1'b0}}};
      end
      for (int p = 0; p < NUM_PLANES; p++) begin
         off_term = {{(DIST_W-COORD_W-FRAC_W){offs[p][COORD_W-1]}}, offs[p],
                     {FRAC_W{1'b0}}};
         far_sum  = off_term + rad_term;
         near_sum = off_term;
         for (int a = 0; a < AXES; a++) begin
            far_sum  = far_sum +
                       {{(DIST_W-PROD_W){s2_far_ff[p][a][PROD_W-1]}}, s2_far_ff[p][a]};
            near_sum = near_sum +
                       {{(DIST_W-PROD_W){s2_near_ff[p][a][PROD_W-1]}}, s2_near_ff[p][a]};
         end
         s3_out_in[p]  = far_sum[DIST_W-1];
         s3_part_in[p] = near_sum[DIST_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready) begin
         s3_func_ff <= s2_func_ff;
         s3_out_ff  <= s3_out_in;
         s3_part_ff <= s3_part_in;
      end
   end

   // ---------------------------------------------------------------
   // stage 4: verdict
   // ---------------------------------------------------------------
   always_comb begin
      priority if (s3_func_ff == FUNC_RESERVED) begin
         verdict_in = VERDICT_OUTSIDE;
      end else if (|s3_out_ff) begin
         verdict_in = VERDICT_OUTSIDE;
      end else if ((s3_func_ff == FUNC_BOX) && (|s3_part_ff)) begin
         verdict_in = VERDICT_PARTIAL;
      end else begin
         verdict_in = VERDICT_INSIDE;
      end
   end

   always_ff @(posedge clock) begin
      if (s4_ready) begin
         verdict_ff <= verdict_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = verdict_ff;

endmodule

### src/fct_chk.sv
`include "assert_macros.svh"

module fct_chk
   import fct_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [VERDICT_W-1:0] rsp_verdict
);

   // stalled result beat holds
   `FCT_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_verdict), "rsp beat changed while stalled")

   `FCT_ASSERT(a_verdict_code, clock, reset, rsp_valid |-> (rsp_verdict == VERDICT_OUTSIDE || rsp_verdict == VERDICT_INSIDE || rsp_verdict == VERDICT_PARTIAL), "illegal verdict code")

   `FCT_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "rsp_valid high right after reset")

   // a free output stage frees every stage behind it
   `FCT_ASSERT(a_ready_chain, clock, reset, (rsp_ready || !rsp_valid) |-> req_ready, "req_ready low with output stage free")

   // input beats are only offered by the sender; keep it visible for debug
   `FCT_ASSERT(a_req_hold, clock, reset, req_valid && !req_ready |=> req_valid, "req beat dropped while stalled")

endmodule

bind frustum_cull_test_unit fct_chk u_fct_chk (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_verdict (rsp_verdict)
);

### tb/frustum_cull_test_unit_tb.sv
module frustum_cull_test_unit_tb;
   import fct_pkg::*;

   localparam int PLANE_COUNT = 6;
   localparam int CSR_INDEX_W = 3;
   localparam int UNUSED_REG  = 7;
   localparam int QUIET_LIMIT = 3000;
   localparam int HALF_EXTENT = 12800;   // 50.0 in Q8.8
   localparam int UNIT_NORMAL = 16384;   // 1.0 in Q1.14

   typedef struct {
      func_type                   func;
      logic signed [COORD_W-1:0]  ax, ay, az;
      logic signed [COORD_W-1:0]  bx, by, bz;
      logic [RADIUS_W-1:0]        radius;
   } cull_object_type;

   class cull_scoreboard;
      logic [PLANE_W-1:0] planes [PLANE_COUNT];
      verdict_type        verdict_q [$];
      int                 errors;

      function new();
         foreach (planes[k]) planes[k] = '0;
         errors = 0;
      endfunction

      function void set_plane(int idx, logic [PLANE_W-1:0] value);
         if (idx < PLANE_COUNT) planes[idx] = value;
      endfunction

      function longint plane_term(int k, int f);
         logic signed [COORD_W-1:0] v;
         v = planes[k][COORD_W*f +: COORD_W];
         return longint'(v);
      endfunction

      // n.p + d with d scaled up to the Q.22 product format
      function longint distance(int k, longint x, longint y, longint z);
         return plane_term(k, 0) * x + plane_term(k, 1) * y + plane_term(k, 2) * z
                + plane_term(k, 3) * 64'sd16384;
      endfunction

      function verdict_type predict_verdict(cull_object_type obj);
         longint reach, far_d, near_d;
         bit     partial, pos_x, pos_y, pos_z;
         partial = 1'b0;
         reach   = longint'(obj.radius) * 64'sd16384;
         if (obj.func == FUNC_RESERVED) return VERDICT_OUTSIDE;
         for (int k = 0; k < PLANE_COUNT; k++) begin
            case (obj.func)
               FUNC_POINT: begin
                  if (distance(k, obj.ax, obj.ay, obj.az) < 0) return VERDICT_OUTSIDE;
               end
               FUNC_SPHERE: begin
                  if (distance(k, obj.ax, obj.ay, obj.az) < -reach) return VERDICT_OUTSIDE;
               end
               default: begin
                  // corner furthest along the normal, no swap for inverted boxes
                  pos_x  = !planes[k][COORD_W-1];
                  pos_y  = !planes[k][2*COORD_W-1];
                  pos_z  = !planes[k][3*COORD_W-1];
                  far_d  = distance(k, pos_x ? obj.bx : obj.ax, pos_y ? obj.by : obj.ay,
                                    pos_z ? obj.bz : obj.az);
                  near_d = distance(k, pos_x ? obj.ax : obj.bx, pos_y ? obj.ay : obj.by,
                                    pos_z ? obj.az : obj.bz);
                  if (far_d < 0) return VERDICT_OUTSIDE;
                  if (near_d < 0) partial = 1'b1;
               end
            endcase
         end
         return partial ? VERDICT_PARTIAL : VERDICT_INSIDE;
      endfunction

      function void note_object(cull_object_type obj);
         verdict_q.push_back(predict_verdict(obj));
      endfunction

      function void check_verdict(logic [VERDICT_W-1:0] got);
         verdict_type want;
         if (verdict_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("verdict beat %0d with nothing pending", got);
            return;
         end
         want = verdict_q.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10) $display("verdict mismatch: expected %0d got %0d", want, got);
         end
      endfunction

      function int pending();
         return verdict_q.size();
      endfunction
   endclass

   logic                       clock       = 1'b0;
   logic                       reset       = 1'b1;
   logic                       req_valid   = 1'b0;
   logic                       req_ready;
   logic [FUNC_W-1:0]          req_func    = '0;
   logic signed [COORD_W-1:0]  req_ax      = '0;
   logic signed [COORD_W-1:0]  req_ay      = '0;
   logic signed [COORD_W-1:0]  req_az      = '0;
   logic signed [COORD_W-1:0]  req_bx      = '0;
   logic signed [COORD_W-1:0]  req_by      = '0;
   logic signed [COORD_W-1:0]  req_bz      = '0;
   logic [RADIUS_W-1:0]        req_radius  = '0;
   logic                       rsp_valid;
   logic                       rsp_ready   = 1'b0;
   logic [VERDICT_W-1:0]       rsp_verdict;
   logic                       csr_we      = 1'b0;
   logic [CSR_INDEX_W-1:0]     csr_index   = '0;
   logic [PLANE_W-1:0]         csr_wdata   = '0;

   cull_scoreboard board;
   int idle_pct    = 0;
   int stall_pct   = 0;
   int hold_cycles = 0;
   int ready_gap;
   int quiet_cycles = 0;

   frustum_cull_test_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_func    (req_func),
      .req_ax      (req_ax),
      .req_ay      (req_ay),
      .req_az      (req_az),
      .req_bx      (req_bx),
      .req_by      (req_by),
      .req_bz      (req_bz),
      .req_radius  (req_radius),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_verdict (rsp_verdict),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int pick_gap(int pct);
      if (pct == 0 || $urandom_range(99) >= pct) return 0;
      if ($urandom_range(9) == 0) return $urandom_range(40, 10);
      return $urandom_range(3, 1);
   endfunction

   // receiver: random stalls, or one long hold-off on request
   always begin
      @(negedge clock);
      if (hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         repeat (hold_cycles - 1) @(negedge clock);
         hold_cycles = 0;
      end else begin
         ready_gap = pick_gap(stall_pct);
         if (ready_gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (ready_gap - 1) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_verdict(rsp_verdict);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   function automatic logic [PLANE_W-1:0] pack_plane(int nx, int ny, int nz, int d);
      return {16'(d), 16'(nz), 16'(ny), 16'(nx)};
   endfunction

   function automatic cull_object_type make_object(func_type f, int ax, int ay, int az,
                                                   int bx, int by, int bz, int r);
      cull_object_type obj;
      obj.func   = f;
      obj.ax     = 16'(ax);
      obj.ay     = 16'(ay);
      obj.az     = 16'(az);
      obj.bx     = 16'(bx);
      obj.by     = 16'(by);
      obj.bz     = 16'(bz);
      obj.radius = 15'(r);
      return obj;
   endfunction

   function automatic logic signed [COORD_W-1:0] random_coord(int span);
      if ($urandom_range(9) == 0) return 16'($urandom);
      return 16'(int'($urandom_range(2 * span)) - span);
   endfunction

   function automatic cull_object_type random_object(int span);
      cull_object_type obj;
      logic signed [COORD_W-1:0] tmp;
      int pick;
      pick = $urandom_range(15);
      obj.func = pick < 5 ? FUNC_POINT : pick < 10 ? FUNC_SPHERE
               : pick < 15 ? FUNC_BOX : FUNC_RESERVED;
      obj.ax = random_coord(span);
      obj.ay = random_coord(span);
      obj.az = random_coord(span);
      obj.bx = random_coord(span);
      obj.by = random_coord(span);
      obj.bz = random_coord(span);
      obj.radius = $urandom_range(7) == 0 ? 15'($urandom) : 15'($urandom_range(span / 2));
      // most boxes well formed, the rest left unsorted and possibly inverted
      if ($urandom_range(99) < 85) begin
         if (obj.ax > obj.bx) begin tmp = obj.ax; obj.ax = obj.bx; obj.bx = tmp; end
         if (obj.ay > obj.by) begin tmp = obj.ay; obj.ay = obj.by; obj.by = tmp; end
         if (obj.az > obj.bz) begin tmp = obj.az; obj.az = obj.bz; obj.bz = tmp; end
      end
      return obj;
   endfunction

   task automatic send_object(cull_object_type obj);
      int gap;
      gap = pick_gap(idle_pct);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid  <= 1'b1;
      req_func   <= obj.func;
      req_ax     <= obj.ax;
      req_ay     <= obj.ay;
      req_az     <= obj.az;
      req_bx     <= obj.bx;
      req_by     <= obj.by;
      req_bz     <= obj.bz;
      req_radius <= obj.radius;
      do @(posedge clock); while (!req_ready);
      board.note_object(obj);
   endtask

   task automatic send_random(int count, int span);
      repeat (count) send_object(random_object(span));
   endtask

   task automatic write_plane(int idx, logic [PLANE_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_INDEX_W'(idx);
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      board.set_plane(idx, value);
   endtask

   // stop offering and wait for every pending verdict
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic load_box_frustum(int extent);
      write_plane(0, pack_plane(UNIT_NORMAL, 0, 0, extent));
      write_plane(1, pack_plane(-UNIT_NORMAL, 0, 0, extent));
      write_plane(2, pack_plane(0, UNIT_NORMAL, 0, extent));
      write_plane(3, pack_plane(0, -UNIT_NORMAL, 0, extent));
      write_plane(4, pack_plane(0, 0, UNIT_NORMAL, extent));
      write_plane(5, pack_plane(0, 0, -UNIT_NORMAL, extent));
   endtask

   initial begin
      board = new();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // all planes zero after reset: everything inside, unused selector outside
      send_object(make_object(FUNC_POINT, -32768, -32768, -32768, 0, 0, 0, 0));
      send_object(make_object(FUNC_BOX, 32767, 32767, 32767, 32767, 32767, 32767, 0));
      send_object(make_object(FUNC_SPHERE, 32767, -32768, 32767, 0, 0, 0, 32767));
      send_object(make_object(FUNC_RESERVED, 0, 0, 0, 0, 0, 0, 0));
      settle();

      load_box_frustum(HALF_EXTENT);
      send_object(make_object(FUNC_POINT, 0, 0, 0, 0, 0, 0, 0));
      // distance exactly zero counts as inside
      send_object(make_object(FUNC_POINT, -HALF_EXTENT, 0, 0, 0, 0, 0, 0));
      send_object(make_object(FUNC_POINT, -HALF_EXTENT - 1, 0, 0, 0, 0, 0, 0));
      send_object(make_object(FUNC_POINT, 0, 0, HALF_EXTENT, 0, 0, 0, 0));
      send_object(make_object(FUNC_POINT, 32767, 32767, 32767, 0, 0, 0, 0));
      // sphere exactly at minus its radius, then one step beyond
      send_object(make_object(FUNC_SPHERE, -HALF_EXTENT - 1000, 0, 0, 0, 0, 0, 1000));
      send_object(make_object(FUNC_SPHERE, -HALF_EXTENT - 1001, 0, 0, 0, 0, 0, 1000));
      send_object(make_object(FUNC_SPHERE, 0, 0, 0, 0, 0, 0, 0));
      send_object(make_object(FUNC_SPHERE, -32768, 0, 0, 0, 0, 0, 32767));
      send_object(make_object(FUNC_BOX, -100, -100, -100, 100, 100, 100, 0));
      send_object(make_object(FUNC_BOX, -HALF_EXTENT - 10, -100, -100, 0, 100, 100, 0));
      send_object(make_object(FUNC_BOX, -32768, 0, 0, -HALF_EXTENT - 1, 10, 10, 0));
      send_object(make_object(FUNC_BOX, -32768, -32768, -32768, 32767, 32767, 32767, 0));
      send_object(make_object(FUNC_BOX, 0, 0, 0, HALF_EXTENT, HALF_EXTENT, HALF_EXTENT, 0));
      // inverted boxes are used as given
      send_object(make_object(FUNC_BOX, 100, 100, 100, -100, -100, -100, 0));
      send_object(make_object(FUNC_BOX, HALF_EXTENT + 5, 0, 0, 0, 10, 10, 0));
      send_object(make_object(FUNC_RESERVED, -1, -1, -1, -1, -1, -1, 32767));

      idle_pct  = 30;
      stall_pct = 30;
      send_random(260, 16000);
      settle();

      // tilted planes with the origin inside
      for (int k = 0; k < PLANE_COUNT; k++) begin
         write_plane(k, pack_plane(int'($urandom_range(32768)) - 16384,
                                   int'($urandom_range(32768)) - 16384,
                                   int'($urandom_range(32768)) - 16384,
                                   $urandom_range(12800, 2560)));
      end
      idle_pct  = 0;
      stall_pct = 0;
      send_random(100, 12000);
      // long receiver hold-off while the sender keeps offering
      hold_cycles = 400;
      send_random(80, 12000);
      idle_pct  = 20;
      stall_pct = 40;
      send_random(150, 12000);
      settle();

      for (int k = 0; k < PLANE_COUNT; k++) write_plane(k, {$urandom, $urandom});
      idle_pct  = 10;
      stall_pct = 10;
      send_random(130, 20000);
      settle();

      // extreme plane values; the unused index must leave the planes alone
      write_plane(0, pack_plane(-32768, -32768, -32768, 32767));
      write_plane(1, pack_plane(32767, 32767, 32767, -32768));
      write_plane(2, pack_plane(32767, -32768, 32767, 32767));
      write_plane(3, pack_plane(-32768, 32767, -32768, -32768));
      write_plane(4, pack_plane(0, 0, 0, 32767));
      write_plane(5, pack_plane(32767, 0, -32768, 0));
      write_plane(UNUSED_REG, '1);
      send_random(110, 32767);
      settle();

      if (board.errors == 0 && board.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
